// ===== hdl/clr_pkg.sv =====
// ----------------------------------------------------------------------------
// clr_pkg
// types, command table and character constants for the command line recognizer
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int unsigned NumCmds  = 14;
  localparam int unsigned WordBits = 128;

  localparam logic [7:0]  Colon     = 8'h3A;
  localparam logic [7:0]  Cr        = 8'h0D;
  localparam logic [7:0]  Lf        = 8'h0A;
  localparam logic [31:0] AsciiZero = 32'd48;

  // commands that take a decimal argument after the colon
  localparam logic [NumCmds-1:0] CmdHasColon = 14'b00110110000111;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_end;
  } clr_in_t;

  typedef struct packed {
    logic        matched;
    logic [3:0]  command_index;
    logic [31:0] argument;
  } clr_out_t;

  typedef struct packed {
    logic [4:0]         position;
    logic [NumCmds-1:0] alive_mask;
    logic               hit_flag;
    logic [3:0]         hit_index;
    logic               in_argument;
    logic               argument_done;
    logic [31:0]        accumulator;
  } clr_state_t;

  localparam clr_state_t StateReset = '{
    position:      '0,
    alive_mask:    '1,
    hit_flag:      1'b0,
    hit_index:     '0,
    in_argument:   1'b0,
    argument_done: 1'b0,
    accumulator:   '0
  };

  // command text without the trailing cr lf, ascii bytes, right aligned
  function automatic logic [WordBits-1:0] cmd_word(input logic [3:0] idx);
    case (idx)
      4'd0:    return WordBits'(72'h7365745f74696d653a);
      4'd1:    return WordBits'(72'h7365745f646174653a);
      4'd2:    return WordBits'(64'h636f6e6e6563743a);
      4'd3:    return WordBits'(64'h6765745f74696d65);
      4'd4:    return WordBits'(64'h6765745f64617461);
      4'd5:    return WordBits'(72'h63616c696272617465);
      4'd6:    return WordBits'(112'h656e645f636f6e6e656374696f6e);
      4'd7:    return WordBits'(120'h7365745f66697273745f706173733a);
      4'd8:    return WordBits'(128'h7365745f7365636f6e645f706173733a);
      4'd9:    return WordBits'(96'h72657365745f6d6574657273);
      4'd10:   return WordBits'(104'h7365745f6461796c696768743a);
      4'd11:   return WordBits'(128'h6368616e67655f6461796c696768743a);
      4'd12:   return WordBits'(120'h6765745f6576656e745f6e6f746573);
      4'd13:   return WordBits'(96'h6765745f7465725f64617461);
      default: return '0;
    endcase
  endfunction

  function automatic logic [4:0] cmd_len(input logic [3:0] idx);
    case (idx)
      4'd0:    return 5'd9;
      4'd1:    return 5'd9;
      4'd2:    return 5'd8;
      4'd3:    return 5'd8;
      4'd4:    return 5'd8;
      4'd5:    return 5'd9;
      4'd6:    return 5'd14;
      4'd7:    return 5'd15;
      4'd8:    return 5'd16;
      4'd9:    return 5'd12;
      4'd10:   return 5'd13;
      4'd11:   return 5'd16;
      4'd12:   return 5'd15;
      4'd13:   return 5'd12;
      default: return 5'd0;
    endcase
  endfunction

  // byte of the full command line at a position, zero past its end
  function automatic logic [7:0] cmd_char(input logic [3:0] idx, input logic [4:0] pos);
    logic [4:0]          len;
    logic [WordBits-1:0] word;
    logic [4:0]          diff;
    logic [6:0]          sh;
    len  = cmd_len(idx);
    word = cmd_word(idx);
    diff = len - 5'd1 - pos;
    sh   = {diff[3:0], 3'b000};
    if (pos < len) begin
      return word[sh +: 8];
    end else if (pos == len) begin
      return Cr;
    end else if (pos == len + 5'd1) begin
      return Lf;
    end else begin
      return 8'h00;
    end
  endfunction

endpackage

// ===== hdl/clr_matcher.sv =====
// ----------------------------------------------------------------------------
// clr_matcher
// next line state and frame result for one received byte
// ----------------------------------------------------------------------------
module clr_matcher (
  input  clr_pkg::clr_state_t cur_i,
  input  logic [7:0]          byte_i,
  output clr_pkg::clr_state_t nxt_o,
  output clr_pkg::clr_out_t   res_o
);

  logic [clr_pkg::NumCmds-1:0] kill;
  logic [clr_pkg::NumCmds-1:0] hit;
  logic [clr_pkg::NumCmds-1:0] colon_hit;
  logic [3:0]                  low_idx;
  logic [31:0]                 acc_x10;

  for (genvar c = 0; c < clr_pkg::NumCmds; c++) begin : g_lane
    logic [7:0] ch;
    logic [4:0] len;
    logic       at_last;
    logic       alive;
    assign ch      = clr_pkg::cmd_char(4'(c), cur_i.position);
    assign len     = clr_pkg::cmd_len(4'(c));
    assign at_last = cur_i.position == len + 5'd1;
    assign alive   = cur_i.alive_mask[c];
    assign kill[c] = alive & ((ch == 8'h00) | (byte_i == clr_pkg::Colon) |
                              (byte_i != ch) | at_last);
    assign hit[c]  = alive & (ch != 8'h00) & (byte_i == ch) &
                     ((byte_i == clr_pkg::Colon) | at_last);
    assign colon_hit[c] = alive & (byte_i == clr_pkg::Colon) & (ch == clr_pkg::Colon);
  end

  assign acc_x10 = {cur_i.accumulator[28:0], 3'b000} + {cur_i.accumulator[30:0], 1'b0};

  always_comb begin
    low_idx = '0;
    for (int i = clr_pkg::NumCmds - 1; i >= 0; i--) begin
      if (hit[i]) begin
        low_idx = 4'(i);
      end
    end
  end

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.in_argument && !cur_i.argument_done) begin
      if (byte_i == clr_pkg::Cr) begin
        nxt_o.argument_done = 1'b1;
      end else begin
        nxt_o.accumulator = acc_x10 + {24'd0, byte_i} - clr_pkg::AsciiZero;
      end
    end
    nxt_o.alive_mask = cur_i.alive_mask & ~kill;
    if (|colon_hit) begin
      nxt_o.in_argument = 1'b1;
    end
    if ((|hit) && (!cur_i.hit_flag || low_idx < cur_i.hit_index)) begin
      nxt_o.hit_flag  = 1'b1;
      nxt_o.hit_index = low_idx;
    end
    if (cur_i.position != 5'd31) begin
      nxt_o.position = cur_i.position + 5'd1;
    end
  end

  always_comb begin
    res_o.matched       = nxt_o.hit_flag;
    res_o.command_index = nxt_o.hit_flag ? nxt_o.hit_index : 4'd0;
    if (nxt_o.hit_flag && (nxt_o.hit_index < 4'(clr_pkg::NumCmds)) &&
        clr_pkg::CmdHasColon[nxt_o.hit_index]) begin
      res_o.argument = nxt_o.accumulator;
    end else begin
      res_o.argument = '0;
    end
  end

endmodule

// ===== hdl/command_line_recognizer_top.sv =====
// the result of a line is registered in the output register, or in the skid register while the output stalls
// throughput: one byte per cycle while in_stall_o is low, a line state register updated in a single pass
// a two-entry output register and skid stage keep bytes flowing while a result waits
// reset clears the line state to the start of a line and empties the output stages
// ----------------------------------------------------------------------------
// command_line_recognizer_top
// matches received line bytes against the command table and reports the command
// ----------------------------------------------------------------------------
module command_line_recognizer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  clr_pkg::clr_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output clr_pkg::clr_out_t  out_data_o
);

  clr_pkg::clr_state_t state_q, state_d;
  clr_pkg::clr_out_t   res;
  clr_pkg::clr_out_t   out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic                in_acc, res_push, out_free;

  clr_matcher u_matcher (
    .cur_i  (state_q),
    .byte_i (in_data_i.byte_value),
    .nxt_o  (state_d),
    .res_o  (res)
  );

  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i & ~skid_valid_q;
  assign res_push    = in_acc & in_data_i.frame_end;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clr_pkg::StateReset;
    end else if (in_acc) begin
      state_q <= in_data_i.frame_end ? clr_pkg::StateReset : state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_push;
      end
    end else if (res_push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_push) begin
        out_q <= res;
      end
    end else if (res_push) begin
      skid_q <= res;
    end
  end

endmodule
